>>> rtl/core/round_robin_task_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
// Types and codes for the round-robin task scheduler.
// No dependencies; imported by every scheduler module.
`default_nettype none

package rrts_pkg;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_SCHEDULE = 3'd1;
    localparam logic [2:0] OP_DELAY    = 3'd2;
    localparam logic [2:0] OP_EXIT     = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

    typedef enum logic [2:0] {
        SS_FREE    = 3'd0,
        SS_READY   = 3'd1,
        SS_RUNNING = 3'd2,
        SS_BLOCKED = 3'd3,
        SS_DEAD    = 3'd4
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCH_RD,
        ST_SCH_DEM,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] delay_ticks;
    } cmd_item_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  task_slot;
        logic [31:0] wake_time;
        logic [31:0] tick_now;
    } rsp_item_t;

endpackage

`default_nettype wire

>>> rtl/core/rrts_state_mem.sv
// Slot state memory: one write port, one registered read port.
// Per-entry valid flops give the reset image (slot 0 running, rest free). Uses rrts_pkg.
`default_nettype none

module rrts_state_mem #(
    parameter int SLOT_COUNT = 8,
    parameter int SW = 3
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      rd_en,
    input  wire  [SW-1:0]            rd_addr,
    output rrts_pkg::slot_state_t    rd_data,
    input  wire                      wr_en,
    input  wire  [SW-1:0]            wr_addr,
    input  rrts_pkg::slot_state_t    wr_data
);
    import rrts_pkg::*;

    slot_state_t            mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  vld_reg;
    slot_state_t            rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Entries never written read as their reset state.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (vld_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else if (rd_addr == '0)
            begin
                rd_data_reg <= SS_RUNNING;
            end
            else
            begin
                rd_data_reg <= SS_FREE;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/rrts_ctrl.sv
// Scheduler sequencer: op decode, slot scans over the state memory, commit.
// Holds current slot, last pick and tick counter. Uses rrts_pkg and the assert macros.
`default_nettype none
`include "round_robin_task_scheduler_assert.svh"

module rrts_ctrl #(
    parameter int SLOT_COUNT = 8,
    parameter int SW = 3,
    parameter int CW = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  rrts_pkg::cmd_item_t      cmd,
    output logic                     idle,
    output logic                     res_valid,
    input  wire                      res_ready,
    output rrts_pkg::rsp_item_t      res,
    output logic                     rd_en,
    output logic [SW-1:0]            rd_addr,
    input  rrts_pkg::slot_state_t    rd_data,
    output logic                     wr_en,
    output logic [SW-1:0]            wr_addr,
    output rrts_pkg::slot_state_t    wr_data
);
    import rrts_pkg::*;

    state_t      state_reg,   state_next;
    logic [2:0]  op_reg,      op_next;
    logic [31:0] wake_reg,    wake_next;
    logic [31:0] tick_reg,    tick_next;
    logic [SW-1:0] cur_reg,   cur_next;
    logic [SW-1:0] last_reg,  last_next;
    logic [SW-1:0] iss_ptr_reg, iss_ptr_next;
    logic [CW-1:0] iss_cnt_reg, iss_cnt_next;
    logic [SW-1:0] chk_ptr_reg, chk_ptr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [SW-1:0] tgt_reg,   tgt_next;
    logic          status_reg, status_next;

    logic [CW-1:0] scan_total;
    logic [SW-1:0] iss_ptr_inc;
    logic [SW-1:0] last_inc;
    logic          issue;
    logic          hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_TICK;
            wake_reg    <= '0;
            tick_reg    <= '0;
            cur_reg     <= '0;
            last_reg    <= '0;
            iss_ptr_reg <= '0;
            iss_cnt_reg <= '0;
            chk_ptr_reg <= '0;
            chk_vld_reg <= 1'b0;
            tgt_reg     <= '0;
            status_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            wake_reg    <= wake_next;
            tick_reg    <= tick_next;
            cur_reg     <= cur_next;
            last_reg    <= last_next;
            iss_ptr_reg <= iss_ptr_next;
            iss_cnt_reg <= iss_cnt_next;
            chk_ptr_reg <= chk_ptr_next;
            chk_vld_reg <= chk_vld_next;
            tgt_reg     <= tgt_next;
            status_reg  <= status_next;
        end
    end

    assign scan_total  = (op_reg == OP_CREATE) ? CW'(SLOT_COUNT - 1) : CW'(SLOT_COUNT);
    assign iss_ptr_inc = (iss_ptr_reg == SW'(SLOT_COUNT - 1)) ? '0 : iss_ptr_reg + SW'(1);
    assign last_inc    = (last_reg == SW'(SLOT_COUNT - 1)) ? '0 : last_reg + SW'(1);
    assign issue       = (iss_cnt_reg != scan_total);

    // Create takes the first free slot; schedule takes the first ready non-idle slot.
    always_comb
    begin
        if (op_reg == OP_CREATE)
        begin
            hit = chk_vld_reg && (rd_data == SS_FREE);
        end
        else
        begin
            hit = chk_vld_reg && (chk_ptr_reg != '0) && (rd_data == SS_READY);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        wake_next    = wake_reg;
        tick_next    = tick_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        iss_ptr_next = iss_ptr_reg;
        iss_cnt_next = iss_cnt_reg;
        chk_ptr_next = chk_ptr_reg;
        chk_vld_next = 1'b0;
        tgt_next     = tgt_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        rd_addr      = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = SS_READY;
        idle         = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    op_next      = cmd.func;
                    status_next  = STATUS_OK;
                    wake_next    = tick_reg + cmd.delay_ticks;
                    iss_ptr_next = SW'(1);
                    iss_cnt_next = '0;
                    case (cmd.func) inside
                        OP_CREATE:           state_next = ST_SCAN;
                        OP_SCHEDULE:         state_next = ST_SCH_RD;
                        OP_DELAY, OP_EXIT:   state_next = ST_COMMIT;
                        OP_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            state_next = ST_DONE;
                        end
                        default:             state_next = ST_DONE;
                    endcase
                end
            end

            ST_SCH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = ST_SCH_DEM;
            end

            // Demote a running current task before the scan reads the table.
            ST_SCH_DEM:
            begin
                if (rd_data == SS_RUNNING)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = SS_READY;
                end
                iss_ptr_next = last_inc;
                iss_cnt_next = '0;
                state_next   = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    tgt_next   = chk_ptr_reg;
                    state_next = ST_COMMIT;
                end
                else if (!issue && !chk_vld_reg)
                begin
                    tgt_next = '0;
                    if (op_reg == OP_CREATE)
                    begin
                        status_next = STATUS_NO_SLOT;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
                else if (issue)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = iss_ptr_reg;
                    iss_ptr_next = iss_ptr_inc;
                    iss_cnt_next = iss_cnt_reg + CW'(1);
                    chk_ptr_next = iss_ptr_reg;
                    chk_vld_next = 1'b1;
                end
            end

            ST_COMMIT:
            begin
                wr_en      = 1'b1;
                state_next = ST_DONE;
                case (op_reg)
                    OP_CREATE:
                    begin
                        wr_addr = tgt_reg;
                        wr_data = SS_READY;
                    end
                    OP_SCHEDULE:
                    begin
                        wr_addr   = tgt_reg;
                        wr_data   = SS_RUNNING;
                        cur_next  = tgt_reg;
                        last_next = tgt_reg;
                    end
                    OP_DELAY:
                    begin
                        wr_addr = cur_reg;
                        wr_data = SS_BLOCKED;
                    end
                    default:
                    begin
                        wr_addr = cur_reg;
                        wr_data = SS_DEAD;
                    end
                endcase
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status    = status_reg;
        res.task_slot = (op_reg == OP_CREATE) ? 3'(tgt_reg) : 3'(cur_reg);
        res.wake_time = (op_reg == OP_DELAY) ? wake_reg : 32'd0;
        res.tick_now  = tick_reg;
    end

    `RRTS_ASSERT_IMPLY(a_no_write_in_scan, clk, rst_n, state_reg == ST_SCAN, !wr_en,
        "table written during a scan")
    `RRTS_ASSERT_IMPLY(a_start_when_idle, clk, rst_n, start, state_reg == ST_IDLE,
        "item started while busy")
    `RRTS_ASSERT_IMPLY(a_scan_bound, clk, rst_n, state_reg == ST_SCAN,
        iss_cnt_reg <= scan_total, "scan ran past the slot count")
    `RRTS_ASSERT_NEXT(a_pick_tracks, clk, rst_n,
        state_reg == ST_COMMIT && op_reg == OP_SCHEDULE, cur_reg == last_reg,
        "current slot and last pick disagree after schedule")

endmodule

`default_nettype wire

>>> rtl/core/round_robin_task_scheduler.sv
// Throughput: one item at a time; the scan reads one slot state per cycle from the table.
// Reset: async active low; slot 0 running, others free, current slot, last pick, tick zero.
// Output register holds a finished result while the next item is accepted.
// Top level of the round-robin task scheduler; uses rrts_pkg, rrts_ctrl, rrts_state_mem.
`default_nettype none

module round_robin_task_scheduler #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_ready,
    input  rrts_pkg::cmd_item_t    cmd,
    output logic                   rsp_valid,
    input  wire                    rsp_ready,
    output rrts_pkg::rsp_item_t    rsp
);
    import rrts_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic          idle;
    logic          start;
    logic          res_valid;
    logic          res_ready;
    rsp_item_t     res;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    slot_state_t   rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    slot_state_t   wr_data;

    logic          rsp_valid_reg, rsp_valid_next;
    rsp_item_t     rsp_reg,       rsp_next;

    assign cmd_ready = idle;
    assign start     = cmd_valid && idle;
    assign res_ready = !rsp_valid_reg || rsp_ready;

    rrts_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    rrts_state_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Load a finished item whenever the output slot is empty or draining.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> verif/rrts_checker.sv
`timescale 1ns / 100ps
// Checker for the round-robin task scheduler: watches both channels, predicts each result
// from its own copy of the slot table and compares. Depends on rrts_pkg only.
module rrts_checker #(
    parameter int SLOT_COUNT = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  wire                 cmd_ready,
    input  rrts_pkg::cmd_item_t cmd,
    input  wire                 rsp_valid,
    input  wire                 rsp_ready,
    input  rrts_pkg::rsp_item_t rsp,
    output int                  fail_count,
    output int                  pending
);
    import rrts_pkg::*;

    slot_state_t slot_tab [SLOT_COUNT];
    int          cur_task;
    int          last_pick;
    logic [31:0] tick_cnt;
    rsp_item_t   rsp_expected [$];

    // Apply one command to the slot table and return the result it yields.
    task automatic sched_apply(input cmd_item_t c, output rsp_item_t r);
        int probe;
        int pick;
        bit found;
        r = '0;
        r.status = STATUS_OK;
        r.task_slot = 3'(cur_task);
        case (c.func)
            OP_CREATE: begin
                found = 1'b0;
                for (int n = 1; n < SLOT_COUNT; n++) begin
                    if (!found && slot_tab[n] == SS_FREE) begin
                        slot_tab[n] = SS_READY;
                        r.task_slot = 3'(n);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = STATUS_NO_SLOT;
                    r.task_slot = '0;
                end
            end
            OP_SCHEDULE: begin
                if (slot_tab[cur_task] == SS_RUNNING)
                    slot_tab[cur_task] = SS_READY;
                probe = last_pick;
                pick = 0;
                found = 1'b0;
                for (int n = 0; n < SLOT_COUNT; n++) begin
                    probe = (probe + 1) % SLOT_COUNT;
                    if (!found && probe != 0 && slot_tab[probe] == SS_READY) begin
                        pick = probe;
                        found = 1'b1;
                    end
                end
                last_pick = pick;
                cur_task = pick;
                slot_tab[pick] = SS_RUNNING;
                r.task_slot = 3'(pick);
            end
            OP_DELAY: begin
                r.wake_time = tick_cnt + c.delay_ticks;
                slot_tab[cur_task] = SS_BLOCKED;
            end
            OP_EXIT: begin
                slot_tab[cur_task] = SS_DEAD;
            end
            OP_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
            end
            default: begin
            end
        endcase
        r.tick_now = tick_cnt;
    endtask

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t rrts_checker: %s expected %0h actual %0h", $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_item_t want;
        bit        ok;
        if (!rst_n) begin
            for (int n = 0; n < SLOT_COUNT; n++)
                slot_tab[n] = SS_FREE;
            slot_tab[0] = SS_RUNNING;
            cur_task = 0;
            last_pick = 0;
            tick_cnt = '0;
            rsp_expected.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cmd_valid && cmd_ready) begin
                sched_apply(cmd, want);
                rsp_expected.push_back(want);
            end
            if (rsp_valid && rsp_ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t rrts_checker: no item expected, actual %0h", $time, rsp);
                    fail_count++;
                end else begin
                    want = rsp_expected.pop_front();
                    ok = field_ok("status", 32'(want.status), 32'(rsp.status));
                    ok = field_ok("task_slot", 32'(want.task_slot), 32'(rsp.task_slot)) && ok;
                    ok = field_ok("wake_time", want.wake_time, rsp.wake_time) && ok;
                    ok = field_ok("tick_now", want.tick_now, rsp.tick_now) && ok;
                    if (!ok)
                        fail_count++;
                end
            end
            pending = rsp_expected.size();
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, command stimulus, result back-pressure,
// watchdog and verdict. Depends on rrts_pkg, rrts_checker and round_robin_task_scheduler.
module tb_top;
    import rrts_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;
    localparam int         RAND_ITEMS     = 1500;
    localparam int         QUIET_ITEMS    = 200;
    localparam int         PRESS_AT       = 300;
    localparam int         PRESS_CYCLES   = 300;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    wire       cmd_ready;
    cmd_item_t cmd_item;
    wire       rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_item;

    int fail_count;
    int pending;
    int gap_pct;
    bit quiet;
    bit press_req;

    round_robin_task_scheduler #(.SLOT_COUNT(8)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_item)
    );

    rrts_checker #(.SLOT_COUNT(8)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd_item),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one item from a falling edge; return at the falling edge after it is taken.
    task automatic offer(input logic [2:0] f, input logic [31:0] d);
        int gap;
        if (!quiet && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            cmd_valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item.func <= f;
        cmd_item.delay_ticks <= d;
        // cmd_ready only moves at a rising edge, so it is settled at the falling edge.
        while (!cmd_ready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial
    begin
        bit lvl;
        int len;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (press_req)
            begin
                lvl = 1'b0;
                len = PRESS_CYCLES;
                press_req = 1'b0;
            end
            else if (quiet)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 19);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                lvl = 1'b1;
                len = $urandom_range(100, 200);
            end
            else
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 30);
            end
            rsp_ready <= lvl;
            repeat (len) @(negedge clk);
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [2:0]  f;
        logic [31:0] d;
        int          r;
        cmd_valid = 1'b0;
        cmd_item = '0;
        rst_n = 1'b0;
        gap_pct = 20;
        quiet = 1'b0;
        press_req = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: basic flow, wrap of the wake tick, dead slots, idle blocked and killed.
        offer(OP_CREATE, 32'd0);
        offer(OP_SCHEDULE, $urandom);
        offer(OP_TICK, 32'hFFFF_FFFF);
        offer(OP_TICK, 32'd0);
        offer(OP_DELAY, 32'hFFFF_FFFF);
        offer(OP_SCHEDULE, 32'd0);
        offer(OP_CREATE, $urandom);
        offer(OP_SCHEDULE, 32'd0);
        offer(OP_EXIT, 32'd0);
        offer(OP_CREATE, 32'd0);
        offer(OP_SCHEDULE, 32'd0);
        offer(OP_DELAY, 32'd0);
        offer(OP_SCHEDULE, 32'd0);
        offer(OP_DELAY, 32'd12345);
        offer(OP_SCHEDULE, 32'd0);
        offer(OP_EXIT, 32'd0);
        offer(OP_SCHEDULE, 32'd0);
        for (int c = FUNC_SPARE_LO; c <= FUNC_SPARE_HI; c++)
            offer(3'(c), $urandom);
        offer(OP_TICK, 32'd0);
        offer(OP_DELAY, 32'h8000_0000);
        offer(OP_SCHEDULE, 32'hFFFF_FFFF);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    2: gap_pct = 30;
                    default: gap_pct = 60;
                endcase
            end
            if (n == PRESS_AT)
                press_req = 1'b1;
            if (n >= RAND_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            d = $urandom;
            r = $urandom_range(0, 99);
            if (r < 12)
                f = OP_CREATE;
            else if (r < 45)
                f = OP_SCHEDULE;
            else if (r < 70)
                f = OP_TICK;
            else if (r < 78)
            begin
                f = OP_DELAY;
                case ($urandom_range(0, 3))
                    0: d = 32'd0;
                    1: d = 32'hFFFF_FFFF;
                    2: d = $urandom_range(0, 50);
                    default: d = $urandom;
                endcase
            end
            else if (r < 85)
                f = OP_EXIT;
            else
                f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            offer(f, d);
        end
        cmd_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
